>>> rtl/cc20_pkg.sv
package cc20_pkg;

    localparam int DOUBLE_ROUNDS_DEF = 10;

    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;

    localparam logic       REQ_SEED = 1'b0;
    localparam logic       REQ_GEN  = 1'b1;
    localparam logic [3:0] IDX_FIRST = 4'd0;
    localparam logic [3:0] IDX_LAST  = 4'd11;
    localparam logic [6:0] BLOCK_BYTES = 7'd64;

    typedef struct packed {
        logic        req_type;
        logic [3:0]  seed_index;
        logic [31:0] entropy_word;
        logic [31:0] personal_word;
        logic [6:0]  byte_count;
    } in_item_t;

    typedef struct packed {
        logic [7:0] rand_byte;
        logic       status;
        logic       last;
    } out_item_t;

    // Classified command handed from the front part to the back part.
    typedef struct packed {
        logic        is_gen;
        logic [3:0]  seed_index;
        logic [31:0] word;
        logic [6:0]  count;
    } cmd_t;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        rotl = (v << s) | (v >> (32 - s));
    endfunction

    function automatic logic [127:0] quarter(input logic [127:0] q);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        a = q[31:0];
        b = q[63:32];
        c = q[95:64];
        d = q[127:96];
        a = a + b; d = rotl(d ^ a, 16);
        c = c + d; b = rotl(b ^ c, 12);
        a = a + b; d = rotl(d ^ a, 8);
        c = c + d; b = rotl(b ^ c, 7);
        quarter = {d, c, b, a};
    endfunction

endpackage

>>> rtl/cc20_front.sv
module cc20_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  cc20_pkg::in_item_t in_item,
    output logic              cmd_valid,
    input  logic              cmd_pop,
    output cc20_pkg::cmd_t    cmd
);
    import cc20_pkg::*;

    // Two-entry command queue.
    cmd_t       q_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg;
    logic       wr_reg;
    cmd_t       new_cmd;
    logic       do_push;
    logic       do_pop;

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    always_comb
    begin
        new_cmd.is_gen     = (in_item.req_type == REQ_GEN);
        new_cmd.seed_index = in_item.seed_index;
        new_cmd.word       = in_item.entropy_word ^ in_item.personal_word;
        new_cmd.count      = (in_item.byte_count > BLOCK_BYTES) ? BLOCK_BYTES
                                                                : in_item.byte_count;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_reg] <= new_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (do_pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end
endmodule

>>> rtl/cc20_core.sv
module cc20_core #(
    parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [511:0]  init,
    output logic          done,
    output logic [511:0]  block
);
    import cc20_pkg::*;

    localparam int RW = $clog2(2 * DOUBLE_ROUNDS + 1);

    // One half round (four quarter rounds) per cycle.
    logic [511:0]  w_reg;
    logic [511:0]  w_next;
    logic [RW-1:0] rnd_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [31:0]   s [16];
    logic [31:0]   o [16];
    logic [127:0]  r0;
    logic [127:0]  r1;
    logic [127:0]  r2;
    logic [127:0]  r3;

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            s[i] = w_reg[32*i +: 32];
            o[i] = s[i];
        end
        if (!rnd_reg[0])
        begin
            r0 = quarter({s[12], s[8],  s[4], s[0]});
            r1 = quarter({s[13], s[9],  s[5], s[1]});
            r2 = quarter({s[14], s[10], s[6], s[2]});
            r3 = quarter({s[15], s[11], s[7], s[3]});
            {o[12], o[8],  o[4], o[0]} = r0;
            {o[13], o[9],  o[5], o[1]} = r1;
            {o[14], o[10], o[6], o[2]} = r2;
            {o[15], o[11], o[7], o[3]} = r3;
        end
        else
        begin
            r0 = quarter({s[15], s[10], s[5], s[0]});
            r1 = quarter({s[12], s[11], s[6], s[1]});
            r2 = quarter({s[13], s[8],  s[7], s[2]});
            r3 = quarter({s[14], s[9],  s[4], s[3]});
            {o[15], o[10], o[5], o[0]} = r0;
            {o[12], o[11], o[6], o[1]} = r1;
            {o[13], o[8],  o[7], o[2]} = r2;
            {o[14], o[9],  o[4], o[3]} = r3;
        end
        for (int i = 0; i < 16; i++)
        begin
            w_next[32*i +: 32] = o[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            block[32*i +: 32] = w_reg[32*i +: 32] + init[32*i +: 32];
        end
    end

    assign done = done_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            w_reg <= init;
        end
        else if (busy_reg)
        begin
            w_reg <= w_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rnd_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (rnd_reg == RW'(2 * DOUBLE_ROUNDS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                rnd_reg <= rnd_reg + 1'b1;
            end
        end
    end
endmodule

>>> rtl/cc20_back.sv
module cc20_back #(
    parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_pop,
    input  cc20_pkg::cmd_t      cmd,
    output logic                empty,
    input  logic                pop,
    output cc20_pkg::out_item_t out_item
);
    import cc20_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_GEN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]   st_reg;
    logic [31:0]  key_reg [8];
    logic [31:0]  cn_reg [4];
    logic [511:0] ks_reg;
    logic [6:0]   pos_reg;
    logic         seeded_reg;
    logic [6:0]   left_reg;
    logic         ov_reg;
    out_item_t    o_reg;
    logic         start_reg;
    logic         slot_free;
    logic         ov_set;
    logic         core_start;
    logic         core_done;
    logic [511:0] init;
    logic [511:0] blk;
    logic [63:0]  ctr_inc;

    always_comb
    begin
        init[31:0]   = SIGMA0;
        init[63:32]  = SIGMA1;
        init[95:64]  = SIGMA2;
        init[127:96] = SIGMA3;
        for (int i = 0; i < 8; i++)
        begin
            init[128 + 32*i +: 32] = key_reg[i];
        end
        for (int i = 0; i < 4; i++)
        begin
            init[384 + 32*i +: 32] = cn_reg[i];
        end
    end

    cc20_core #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .start (core_start),
        .init  (init),
        .done  (core_done),
        .block (blk)
    );

    assign ctr_inc   = {cn_reg[1], cn_reg[0]} + 64'd1;
    assign slot_free = !ov_reg || pop;
    assign empty     = !ov_reg;
    assign out_item  = o_reg;
    assign cmd_pop   = (st_reg == ST_IDLE) && cmd_valid && slot_free;
    // The core start is registered, so the core sees the new seed or counter when it starts.
    assign core_start = start_reg;
    assign ov_set    = (st_reg == ST_IDLE && cmd_valid && slot_free
                        && (cmd.is_gen ? !seeded_reg : (cmd.seed_index != IDX_LAST)))
                       || (st_reg == ST_GEN && slot_free && pos_reg != BLOCK_BYTES)
                       || (st_reg == ST_WAIT && core_done && left_reg == 7'd0);

    always_ff @(posedge clk)
    begin
        if (core_done)
        begin
            ks_reg <= blk;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ST_IDLE;
            pos_reg    <= '0;
            seeded_reg <= 1'b0;
            left_reg   <= '0;
            ov_reg     <= 1'b0;
            o_reg      <= '0;
            start_reg  <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                key_reg[i] <= '0;
            end
            for (int i = 0; i < 4; i++)
            begin
                cn_reg[i] <= '0;
            end
        end
        else
        begin
            ov_reg    <= ov_set || (ov_reg && !pop);
            start_reg <= (st_reg == ST_IDLE && cmd_valid && slot_free && !cmd.is_gen
                          && cmd.seed_index == IDX_LAST)
                         || (st_reg == ST_GEN && slot_free && pos_reg == BLOCK_BYTES);
            unique case (st_reg)
                ST_IDLE:
                begin
                    if (cmd_valid && slot_free)
                    begin
                        if (!cmd.is_gen)
                        begin
                            if (!cmd.seed_index[3])
                            begin
                                key_reg[cmd.seed_index[2:0]] <= cmd.word;
                            end
                            else if (cmd.seed_index[2] == 1'b0)
                            begin
                                cn_reg[cmd.seed_index[1:0]] <= cmd.word;
                            end
                            if (cmd.seed_index == IDX_FIRST)
                            begin
                                seeded_reg <= 1'b0;
                            end
                            if (cmd.seed_index == IDX_LAST)
                            begin
                                // Acknowledge after the block is ready.
                                st_reg <= ST_WAIT;
                            end
                            else
                            begin
                                o_reg <= '{rand_byte: 8'd0, status: 1'b0, last: 1'b1};
                            end
                        end
                        else if (!seeded_reg)
                        begin
                            o_reg <= '{rand_byte: 8'd0, status: 1'b1, last: 1'b1};
                        end
                        else if (cmd.count != 7'd0)
                        begin
                            left_reg <= cmd.count;
                            st_reg   <= ST_GEN;
                        end
                    end
                end
                ST_GEN:
                begin
                    if (slot_free)
                    begin
                        if (pos_reg == BLOCK_BYTES)
                        begin
                            {cn_reg[1], cn_reg[0]} <= ctr_inc;
                            st_reg <= ST_WAIT;
                        end
                        else
                        begin
                            o_reg.rand_byte <= ks_reg[8*pos_reg[5:0] +: 8];
                            o_reg.status    <= 1'b0;
                            o_reg.last      <= (left_reg == 7'd1);
                            pos_reg         <= pos_reg + 7'd1;
                            left_reg        <= left_reg - 7'd1;
                            if (left_reg == 7'd1)
                            begin
                                st_reg <= ST_IDLE;
                            end
                        end
                    end
                end
                ST_WAIT:
                begin
                    if (core_done)
                    begin
                        pos_reg <= '0;
                        if (left_reg == 7'd0)
                        begin
                            seeded_reg <= 1'b1;
                            o_reg  <= '{rand_byte: 8'd0, status: 1'b0, last: 1'b1};
                            st_reg <= ST_IDLE;
                        end
                        else
                        begin
                            st_reg <= ST_GEN;
                        end
                    end
                end
                default:
                begin
                    st_reg <= ST_IDLE;
                end
            endcase
        end
    end
endmodule

>>> rtl/chacha20_drbg.sv
// A generate word yields one byte per cycle from the buffered block while each byte is popped.
// Seed word eleven delays its acknowledgement until the core has computed the block, and an
// exhausted block stalls the byte stream while the shared half-round unit, doing four
// quarter rounds per cycle, computes the next one.
// A two-entry command queue lets new words enter while bytes are being drained.
// Reset clears key, counter, nonce, byte position and the seeded flag; the block is undefined.
module chacha20_drbg #(
    parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  cc20_pkg::in_item_t  in_item,
    output logic                empty,
    input  logic                pop,
    output cc20_pkg::out_item_t out_item
);
    import cc20_pkg::*;

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_pop;

    cc20_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    cc20_back #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item)
    );
endmodule
